>>> sv/fsfp_pkg.sv
// Package with the types, codes and constants of the file name size field parser.
package fsfp_pkg;

    localparam logic [7:0] CH_COMMA = 8'd44;
    localparam logic [7:0] CH_EQUAL = 8'd61;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    localparam logic [7:0] RST_SIZE_TAG        = 8'd83;
    localparam logic [7:0] RST_INFO_SEPARATOR  = 8'd58;
    localparam logic [7:0] RST_EXTRA_SEPARATOR = 8'd44;

    localparam int unsigned ADDR_W = 4;

    localparam logic [1:0] REG_SIZE_TAG        = 2'd0;
    localparam logic [1:0] REG_INFO_SEPARATOR  = 2'd1;
    localparam logic [1:0] REG_EXTRA_SEPARATOR = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_COMMA   = 3'd1,
        PH_TAG     = 3'd2,
        PH_MATCHED = 3'd3,
        PH_DIGITS  = 3'd4,
        PH_GOOD    = 3'd5,
        PH_BAD     = 3'd6
    } t_phase;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in;

    typedef struct packed {
        logic        found;
        logic [63:0] size;
    } t_out;

    typedef struct packed {
        logic [7:0] size_tag;
        logic [7:0] info_separator;
        logic [7:0] extra_separator;
    } t_cfg;

endpackage

>>> sv/fsfp_step.sv
// Next-state logic of the parser: pattern search, digit accumulation and the result.
module fsfp_step
    import fsfp_pkg::*;
(
    input  t_phase      i_phase,
    input  logic [63:0] i_value,
    input  logic [7:0]  i_ch,
    input  t_cfg        i_cfg,
    output t_phase      o_phase,
    output logic [63:0] o_value,
    output t_out        o_result
);

    logic       is_digit;
    logic       is_sep;
    logic [7:0] digit;

    assign is_digit = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
    assign is_sep   = (i_ch == i_cfg.info_separator) || (i_ch == i_cfg.extra_separator);
    assign digit    = i_ch - CH_ZERO;

    always_comb begin
        unique case (i_phase)
            PH_IDLE: begin
                o_phase = (i_ch == CH_COMMA) ? PH_COMMA : PH_IDLE;
            end
            PH_COMMA: begin
                priority if (i_ch == i_cfg.size_tag) o_phase = PH_TAG;
                else if (i_ch == CH_COMMA)           o_phase = PH_COMMA;
                else                                 o_phase = PH_IDLE;
            end
            PH_TAG: begin
                // With a comma as the tag, a further comma keeps the longest partial match.
                priority if (i_ch == CH_EQUAL)                          o_phase = PH_MATCHED;
                else if (i_ch == CH_COMMA && i_cfg.size_tag == CH_COMMA) o_phase = PH_TAG;
                else if (i_ch == CH_COMMA)                              o_phase = PH_COMMA;
                else                                                    o_phase = PH_IDLE;
            end
            PH_MATCHED, PH_DIGITS: begin
                priority if (is_digit) o_phase = PH_DIGITS;
                else if (is_sep)       o_phase = PH_GOOD;
                else                   o_phase = PH_BAD;
            end
            PH_GOOD: o_phase = PH_GOOD;
            default: o_phase = PH_BAD;
        endcase
    end

    always_comb begin
        o_value = i_value;
        if ((i_phase == PH_MATCHED || i_phase == PH_DIGITS) && is_digit) begin
            // Times ten as two shifts; the sum wraps modulo 2^64.
            o_value = (i_value << 3) + (i_value << 1) + {56'd0, digit};
        end
        o_result.found = (o_phase == PH_DIGITS) || (o_phase == PH_GOOD);
        o_result.size  = o_result.found ? o_value : 64'd0;
    end

endmodule

>>> sv/filename_size_field_parser.sv
// Top level of the file name size field parser with its register port.
//
//   channel   direction  payload  handshake
//   in        input      t_in     i_in_valid / o_in_stall
//   out       output     t_out    o_out_valid / i_out_stall
//   register  input      32 bit   psel, penable, pwrite, pready
//
// One byte is taken per cycle unless a final byte is held back by a stalled output; each
// byte is held in the input register, and the search state and the 64-bit accumulator are
// updated as it leaves, so a result enters the output register as the final byte leaves.
// The accumulator update (times ten plus a digit) closes the loop through the accumulator.
// Reset clears the search state and restores the default tag and separator bytes.
// A stalled output holds back only a final byte; other bytes keep flowing.
module filename_size_field_parser
    import fsfp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in               i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out              o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg        r_cfg;
    logic        r_in_valid;
    t_in         r_in;
    t_phase      r_phase;
    logic [63:0] r_value;
    logic        r_out_valid;
    t_out        r_out;

    t_phase      n_phase;
    logic [63:0] n_value;
    t_out        n_out;

    logic        out_free;
    logic        s1_go;
    logic        in_take;
    logic        cfg_write;
    logic [1:0]  reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        unique case (reg_index)
            REG_SIZE_TAG:        prdata = {24'd0, r_cfg.size_tag};
            REG_INFO_SEPARATOR:  prdata = {24'd0, r_cfg.info_separator};
            REG_EXTRA_SEPARATOR: prdata = {24'd0, r_cfg.extra_separator};
            default:             prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.size_tag        <= RST_SIZE_TAG;
            r_cfg.info_separator  <= RST_INFO_SEPARATOR;
            r_cfg.extra_separator <= RST_EXTRA_SEPARATOR;
        end else if (cfg_write) begin
            unique case (reg_index)
                REG_SIZE_TAG:        r_cfg.size_tag        <= pwdata[7:0];
                REG_INFO_SEPARATOR:  r_cfg.info_separator  <= pwdata[7:0];
                REG_EXTRA_SEPARATOR: r_cfg.extra_separator <= pwdata[7:0];
                default:             ;
            endcase
        end
    end

    // Only a final byte needs room in the output register.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_go      = r_in_valid && (!r_in.last || out_free);
    assign o_in_stall = r_in_valid && !s1_go;
    assign in_take    = i_in_valid && !o_in_stall;

    fsfp_step u_step (
        .i_phase  (r_phase),
        .i_value  (r_value),
        .i_ch     (r_in.ch),
        .i_cfg    (r_cfg),
        .o_phase  (n_phase),
        .o_value  (n_value),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (s1_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_value <= 64'd0;
        end else if (s1_go) begin
            if (r_in.last) begin
                r_phase <= PH_IDLE;
                r_value <= 64'd0;
            end else begin
                r_phase <= n_phase;
                r_value <= n_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_in.last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_in.last) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    // A name that was not found never reports a size.
    a_size_zero_when_missing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.found |-> o_out_data.size == 64'd0)
        else $error("size field reported without a match");

    // The final byte of a name returns the search to its starting point.
    a_restart_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go && r_in.last |=> r_phase == PH_IDLE && r_value == 64'd0)
        else $error("search state not cleared after the final byte");

    // Only digits make the accumulator nonzero.
    a_value_only_after_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_value != 64'd0 |->
            (r_phase == PH_DIGITS || r_phase == PH_GOOD || r_phase == PH_BAD))
        else $error("accumulator nonzero outside the number");

    // A final byte waits while the output register is full and stalled.
    a_last_waits_for_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_in.last && o_out_valid && i_out_stall |=>
            r_in_valid && $stable(r_in))
        else $error("final byte left the input register while output was blocked");
`endif

endmodule
